@@ rtl/core/dwt_pkg.sv @@
package dwt_pkg;

  // fixed widths of the data path
  localparam int SAMPLE_W  = 16;
  localparam int TAP_W     = 16;
  localparam int HI_W      = TAP_W + 1;
  localparam int OUT_W     = 17;
  localparam int FRAC_W    = 15;
  localparam int NTAPS     = 6;
  localparam int LANE_W    = $clog2(NTAPS);
  localparam int CFG_IDX_W = $clog2(NTAPS);

  // products and sums, sized so that nothing can overflow
  localparam int PROD_W = SAMPLE_W + TAP_W;
  localparam int PSUM_W = PROD_W + 1;
  localparam int ACC_W  = PROD_W + 2;

  // sequence handling
  localparam int MAX_LEN  = 65536;
  localparam int CNT_W    = $clog2(MAX_LEN);
  localparam int MIN_LEN  = 5;
  localparam int HEAD_IDX = 3;

  localparam int ROUND_BIAS = 2 ** (FRAC_W - 1);
  localparam int OUT_MAX_V  = 2 ** (OUT_W - 1) - 1;
  localparam int OUT_MIN_V  = -(2 ** (OUT_W - 1));

  // db3 low-pass taps, Q1.15
  localparam logic signed [TAP_W-1:0] TAP_RESET [NTAPS] = '{
    16'sd10901, 16'sd26440, 16'sd15069, -16'sd4424, -16'sd2800, 16'sd1154
  };

  // which window cells feed the six lanes of one coefficient pair
  typedef enum logic [3:0] {
    PAT_ZERO,
    PAT_HEAD0,
    PAT_HEAD1,
    PAT_FULL,
    PAT_E1,
    PAT_E2,
    PAT_O0,
    PAT_O1,
    PAT_O2
  } pat_t;

  typedef struct packed {
    pat_t pat;
    logic fin;
    logic short_seq;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } issue_t;

endpackage

@@ rtl/core/dwt_analysis_single_level.sv @@
// an accepted word runs through job queue, products, pair sums, accumulators and output register
// throughput: one sample per cycle; after the fourth and the last sample of a sequence the
//   input stalls while their pairs issue, as the pair issue unit feeds the shared multiply row
//   one pair a cycle; a too-short sequence never stalls; a stalled output word freezes the pipe
// reset: synchronous, active low; clears counters, job queue, pipeline valids and the
//   sample window, and loads the db3 low-pass taps
module dwt_analysis_single_level
  import dwt_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  // sample channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  input  logic                        in_last,
  // coefficient channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_W-1:0]     out_approx,
  output logic signed [OUT_W-1:0]     out_detail,
  output logic                        out_final_res,
  output logic                        out_too_short,
  // tap register writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic signed [TAP_W-1:0]     cfg_data
);

  logic                       shift_en;
  logic                       pipe_en;
  issue_t                     issue;
  logic signed [SAMPLE_W-1:0] win [NTAPS];
  logic signed [TAP_W-1:0]    taps [NTAPS];
  logic signed [SAMPLE_W-1:0] operand [NTAPS];
  logic signed [PROD_W-1:0]   prod_lo [NTAPS];
  logic signed [PROD_W-1:0]   prod_hi [NTAPS];
  logic [LANE_W-1:0]          src [NTAPS];

  // tap writes are always taken; indexes past the last tap are dropped
  assign cfg_ready = 1'b1;

  // sequencer: sample count, job queue of up to three pairs per word
  dwt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_stall (in_stall),
    .shift_en (shift_en),
    .pipe_en  (pipe_en),
    .issue    (issue)
  );

  // window position feeding each lane, per pair shape
  // win[0] is the oldest sample, win[NTAPS-1] the newest
  always_comb begin
    unique case (issue.job.pat)
      PAT_ZERO:  src = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0};
      // head mirror, both pairs come out with the fourth sample
      PAT_HEAD0: src = '{3'd5, 3'd4, 3'd3, 3'd2, 3'd2, 3'd3};
      PAT_HEAD1: src = '{3'd3, 3'd2, 3'd2, 3'd3, 3'd4, 3'd5};
      // steady state: the six newest samples
      PAT_FULL:  src = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
      // tail mirror, even length
      PAT_E1:    src = '{3'd2, 3'd3, 3'd4, 3'd5, 3'd5, 3'd4};
      PAT_E2:    src = '{3'd4, 3'd5, 3'd5, 3'd4, 3'd3, 3'd2};
      // tail mirror, odd length
      PAT_O0:    src = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5};
      PAT_O1:    src = '{3'd3, 3'd4, 3'd5, 3'd5, 3'd4, 3'd3};
      PAT_O2:    src = '{3'd5, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1};
      default:   src = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0};
    endcase
  end

  // short-sequence word runs zeros through the row so the coefficients come out zero
  always_comb begin
    for (int k = 0; k < NTAPS; k++) begin
      operand[k] = (issue.job.pat == PAT_ZERO) ? '0 : win[src[k]];
    end
  end

  // row of cells: each holds one window sample and one tap, shifts the window
  // toward cell 0 on every accepted word and multiplies its lane operand
  for (genvar k = 0; k < NTAPS; k++) begin : g_cell
    logic signed [SAMPLE_W-1:0] chain_in;

    if (k == NTAPS - 1) begin : g_head
      assign chain_in = in_sample;
    end else begin : g_link
      assign chain_in = win[k+1];
    end

    dwt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .shift_en    (shift_en),
      .sample_in   (chain_in),
      .sample_q    (win[k]),
      .tap_we      (cfg_valid && (cfg_index == CFG_IDX_W'(k))),
      .tap_wdata   (cfg_data),
      .tap_rst_val (TAP_RESET[k]),
      .tap_q       (taps[k]),
      .mirror_tap  (taps[NTAPS-1-k]),
      .negate_hi   (1'(k % 2)),
      .pipe_en     (pipe_en),
      .operand     (operand[k]),
      .prod_lo     (prod_lo[k]),
      .prod_hi     (prod_hi[k])
    );
  end

  // adder tree, rounding, saturation and the output register
  dwt_acc u_acc (
    .clk           (clk),
    .rst_n         (rst_n),
    .issue         (issue),
    .prod_lo       (prod_lo),
    .prod_hi       (prod_hi),
    .pipe_en       (pipe_en),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_approx    (out_approx),
    .out_detail    (out_detail),
    .out_final_res (out_final_res),
    .out_too_short (out_too_short)
  );

`ifndef SYNTHESIS
  // an error word closes its sequence and carries zero coefficients
  a_short_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_short |-> out_final_res && (out_approx == '0) && (out_detail == '0))
    else $error("too_short word with nonzero coefficients or without final_res");

  // a closing sample always leaves work for the pair issue unit, unless the pipe is frozen
  a_last_issues: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> (issue.valid || !pipe_en))
    else $error("last sample accepted but no pair issued");

  // error jobs must run zeros through the multiply row
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    issue.valid && issue.job.short_seq |-> (issue.job.pat == PAT_ZERO) && issue.job.fin)
    else $error("short-sequence job issued with a data shape");
`endif

endmodule

@@ rtl/core/dwt_cell.sv @@
module dwt_cell
  import dwt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift_en,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic signed [SAMPLE_W-1:0] sample_q,
  input  logic                       tap_we,
  input  logic signed [TAP_W-1:0]    tap_wdata,
  input  logic signed [TAP_W-1:0]    tap_rst_val,
  output logic signed [TAP_W-1:0]    tap_q,
  input  logic signed [TAP_W-1:0]    mirror_tap,
  input  logic                       negate_hi,
  input  logic                       pipe_en,
  input  logic signed [SAMPLE_W-1:0] operand,
  output logic signed [PROD_W-1:0]   prod_lo,
  output logic signed [PROD_W-1:0]   prod_hi
);

  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [TAP_W-1:0]    tap_r;
  logic signed [PROD_W-1:0]   prod_lo_r;
  logic signed [PROD_W-1:0]   prod_hi_r;
  logic signed [HI_W-1:0]     hi_tap;
  logic signed [PROD_W-1:0]   op_ext;
  logic signed [PROD_W-1:0]   lo_ext;
  logic signed [PROD_W-1:0]   hi_ext;

  // high-pass tap is the mirrored low-pass tap, negated on odd lanes
  assign hi_tap = negate_hi ? -HI_W'(mirror_tap) : HI_W'(mirror_tap);
  assign op_ext = PROD_W'(operand);
  assign lo_ext = PROD_W'(tap_r);
  assign hi_ext = PROD_W'(hi_tap);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      tap_r    <= tap_rst_val;
    end else begin
      if (shift_en) begin
        sample_r <= sample_in;
      end
      if (tap_we) begin
        tap_r <= tap_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      prod_lo_r <= op_ext * lo_ext;
      prod_hi_r <= op_ext * hi_ext;
    end
  end

  assign sample_q = sample_r;
  assign tap_q    = tap_r;
  assign prod_lo  = prod_lo_r;
  assign prod_hi  = prod_hi_r;

endmodule

@@ rtl/core/dwt_ctrl.sv @@
module dwt_ctrl
  import dwt_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   in_last,
  output logic   in_stall,
  output logic   shift_en,
  input  logic   pipe_en,
  output issue_t issue
);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  job_t             jobs_r [3];
  job_t             jobs_nxt [3];
  logic [1:0]       jcnt_r;
  logic [1:0]       jcnt_nxt;
  job_t             nj [3];
  logic [1:0]       nj_cnt;
  logic             accept;
  logic             issue_go;
  logic             eff_last;

  assign in_stall = !(pipe_en && (jcnt_r <= 2'd1));
  assign accept   = in_valid && !in_stall;
  assign shift_en = accept;
  assign issue_go = pipe_en && (jcnt_r != 2'd0);
  assign eff_last = in_last || (cnt_r == CNT_W'(MAX_LEN - 1));

  // pairs caused by the word now at the input
  always_comb begin
    nj[0]  = '{pat: PAT_ZERO, fin: 1'b0, short_seq: 1'b0};
    nj[1]  = '{pat: PAT_ZERO, fin: 1'b0, short_seq: 1'b0};
    nj[2]  = '{pat: PAT_ZERO, fin: 1'b0, short_seq: 1'b0};
    nj_cnt = 2'd0;
    priority if (eff_last && (cnt_r < CNT_W'(MIN_LEN - 1))) begin
      nj[0]  = '{pat: PAT_ZERO, fin: 1'b1, short_seq: 1'b1};
      nj_cnt = 2'd1;
    end else if (eff_last && cnt_r[0]) begin
      nj[0]  = '{pat: PAT_FULL, fin: 1'b0, short_seq: 1'b0};
      nj[1]  = '{pat: PAT_E1, fin: 1'b0, short_seq: 1'b0};
      nj[2]  = '{pat: PAT_E2, fin: 1'b1, short_seq: 1'b0};
      nj_cnt = 2'd3;
    end else if (eff_last) begin
      nj[0]  = '{pat: PAT_O0, fin: 1'b0, short_seq: 1'b0};
      nj[1]  = '{pat: PAT_O1, fin: 1'b0, short_seq: 1'b0};
      nj[2]  = '{pat: PAT_O2, fin: 1'b1, short_seq: 1'b0};
      nj_cnt = 2'd3;
    end else if (cnt_r == CNT_W'(HEAD_IDX)) begin
      nj[0]  = '{pat: PAT_HEAD0, fin: 1'b0, short_seq: 1'b0};
      nj[1]  = '{pat: PAT_HEAD1, fin: 1'b0, short_seq: 1'b0};
      nj_cnt = 2'd2;
    end else if (cnt_r[0] && (cnt_r > CNT_W'(HEAD_IDX))) begin
      nj[0]  = '{pat: PAT_FULL, fin: 1'b0, short_seq: 1'b0};
      nj_cnt = 2'd1;
    end
  end

  // job queue: shift on issue, reload on accept (queue is empty by then)
  always_comb begin
    jobs_nxt = jobs_r;
    jcnt_nxt = jcnt_r;
    cnt_nxt  = cnt_r;
    if (issue_go) begin
      jobs_nxt[0] = jobs_r[1];
      jobs_nxt[1] = jobs_r[2];
      jcnt_nxt    = jcnt_r - 2'd1;
    end
    if (accept) begin
      jobs_nxt = nj;
      jcnt_nxt = nj_cnt;
      cnt_nxt  = eff_last ? '0 : cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      jcnt_r <= 2'd0;
    end else begin
      cnt_r  <= cnt_nxt;
      jcnt_r <= jcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    jobs_r <= jobs_nxt;
  end

  assign issue.valid = issue_go;
  assign issue.job   = jobs_r[0];

endmodule

@@ rtl/core/dwt_acc.sv @@
module dwt_acc
  import dwt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  issue_t                   issue,
  input  logic signed [PROD_W-1:0] prod_lo [NTAPS],
  input  logic signed [PROD_W-1:0] prod_hi [NTAPS],
  output logic                     pipe_en,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [OUT_W-1:0]  out_approx,
  output logic signed [OUT_W-1:0]  out_detail,
  output logic                     out_final_res,
  output logic                     out_too_short
);

  localparam int Q_W = ACC_W + 1 - FRAC_W;
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(OUT_MAX_V);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(OUT_MIN_V);

  logic                     v1_r, v2_r, v3_r, out_valid_r;
  logic                     fin1_r, fin2_r, fin3_r, fin_out_r;
  logic                     sh1_r, sh2_r, sh3_r, sh_out_r;
  logic signed [PSUM_W-1:0] psum_lo_r [3];
  logic signed [PSUM_W-1:0] psum_hi_r [3];
  logic signed [ACC_W-1:0]  acc_lo_r;
  logic signed [ACC_W-1:0]  acc_hi_r;
  logic signed [OUT_W-1:0]  approx_r;
  logic signed [OUT_W-1:0]  detail_r;

  // add half an lsb, floor, clamp
  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] biased;
    logic signed [Q_W-1:0] q;
    biased = (ACC_W + 1)'(acc) + (ACC_W + 1)'(ROUND_BIAS);
    q      = Q_W'(biased >>> FRAC_W);
    if (q > Q_MAX) begin
      q = Q_MAX;
    end else if (q < Q_MIN) begin
      q = Q_MIN;
    end
    return OUT_W'(q);
  endfunction

  assign pipe_en = !(out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r        <= issue.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      fin1_r <= issue.job.fin;
      sh1_r  <= issue.job.short_seq;
      for (int i = 0; i < 3; i++) begin
        psum_lo_r[i] <= PSUM_W'(prod_lo[2*i]) + PSUM_W'(prod_lo[2*i+1]);
        psum_hi_r[i] <= PSUM_W'(prod_hi[2*i]) + PSUM_W'(prod_hi[2*i+1]);
      end
      fin2_r    <= fin1_r;
      sh2_r     <= sh1_r;
      acc_lo_r  <= ACC_W'(psum_lo_r[0]) + ACC_W'(psum_lo_r[1]) + ACC_W'(psum_lo_r[2]);
      acc_hi_r  <= ACC_W'(psum_hi_r[0]) + ACC_W'(psum_hi_r[1]) + ACC_W'(psum_hi_r[2]);
      fin3_r    <= fin2_r;
      sh3_r     <= sh2_r;
      approx_r  <= round_sat(acc_lo_r);
      detail_r  <= round_sat(acc_hi_r);
      fin_out_r <= fin3_r;
      sh_out_r  <= sh3_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_approx    = approx_r;
  assign out_detail    = detail_r;
  assign out_final_res = fin_out_r;
  assign out_too_short = sh_out_r;

endmodule
